// ===== sv/pod_pkg.sv =====
package pod_pkg;

    // Widths of the configuration registers, fixed by the register map.
    localparam int DECAY_BITS     = 24;
    localparam int HOLD_REG_BITS  = 20;
    localparam int MIN_BITS       = 15;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FAST_DECAY     = 2'd0,
        CFG_SLOW_DECAY     = 2'd1,
        CFG_HOLDOFF_LENGTH = 2'd2,
        CFG_MIN_LEVEL      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [DECAY_BITS-1:0]    fast_decay;
        logic [DECAY_BITS-1:0]    slow_decay;
        logic [HOLD_REG_BITS-1:0] holdoff_length;
        logic [MIN_BITS-1:0]      min_level;
    } t_cfg;

    localparam logic [DECAY_BITS-1:0]    RST_FAST_DECAY     = 24'd16776050;
    localparam logic [DECAY_BITS-1:0]    RST_SLOW_DECAY     = 24'd16777171;
    localparam logic [HOLD_REG_BITS-1:0] RST_HOLDOFF_LENGTH = 20'd14400;
    localparam logic [MIN_BITS-1:0]      RST_MIN_LEVEL      = 15'd7;

endpackage

// ===== sv/pod_env_update.sv =====
// One envelope step: jump to the sample on a rise, otherwise decay toward it.
module pod_env_update #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic [SAMPLE_BITS+COEF_FRAC_BITS-1:0] i_env,
    input  logic [SAMPLE_BITS+COEF_FRAC_BITS-1:0] i_xs,
    input  logic [COEF_FRAC_BITS-1:0]             i_decay,
    output logic [SAMPLE_BITS+COEF_FRAC_BITS-1:0] o_env,
    output logic                                  o_rise
);
    localparam int EB = SAMPLE_BITS + COEF_FRAC_BITS;

    logic [EB-1:0]                w_diff;
    logic [EB+COEF_FRAC_BITS-1:0] w_prod;
    logic [EB-1:0]                w_step;

    // The distance is positive whenever it is used, and it always fits EB unsigned bits.
    assign w_diff = i_env - i_xs;
    assign w_prod = (EB+COEF_FRAC_BITS)'(w_diff) * (EB+COEF_FRAC_BITS)'(i_decay);
    assign w_step = w_prod[EB+COEF_FRAC_BITS-1:COEF_FRAC_BITS];

    assign o_rise = $signed(i_xs) >= $signed(i_env);
    assign o_env  = o_rise ? i_xs : i_xs + w_step;

endmodule

// ===== sv/pod_onset.sv =====
// Onset decision: rise flag, holdoff counter and the level checks.
module pod_onset #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 24,
    parameter int HOLDOFF_BITS   = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic                                  i_fast_rise,
    input  logic [SAMPLE_BITS+COEF_FRAC_BITS-1:0] i_fast_env,
    input  logic [SAMPLE_BITS+COEF_FRAC_BITS-1:0] i_slow_env,
    input  pod_pkg::t_cfg                         i_cfg,
    output logic                                  o_emit
);
    localparam int EB = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int CW = EB + pod_pkg::MIN_BITS + 1;

    logic                                     r_rising;
    logic                                     n_rising;
    logic [HOLDOFF_BITS-1:0]                  r_holdoff;
    logic [HOLDOFF_BITS-1:0]                  n_holdoff;
    logic [HOLDOFF_BITS+pod_pkg::HOLD_REG_BITS-1:0] w_len_ext;
    logic [HOLDOFF_BITS-1:0]                  w_len;
    logic [CW-1:0]                            w_fast_wide;
    logic [CW-1:0]                            w_min_wide;
    logic                                     w_half_ok;
    logic                                     w_min_ok;

    // The holdoff length is cut or padded to the counter width.
    assign w_len_ext = {{HOLDOFF_BITS{1'b0}}, i_cfg.holdoff_length};
    assign w_len     = w_len_ext[HOLDOFF_BITS-1:0];

    // Twice the fast envelope against the slow one is the same as fast >= slow / 2.
    assign w_half_ok = $signed({i_fast_env, 1'b0}) >= $signed({i_slow_env[EB-1], i_slow_env});

    assign w_fast_wide = {{(CW-EB){i_fast_env[EB-1]}}, i_fast_env};
    assign w_min_wide  = {{(SAMPLE_BITS+1){1'b0}}, i_cfg.min_level, {COEF_FRAC_BITS{1'b0}}};
    assign w_min_ok    = $signed(w_fast_wide) > $signed(w_min_wide);

    assign o_emit = !i_fast_rise && r_rising && (r_holdoff == '0) && w_half_ok && w_min_ok;

    always_comb begin
        n_rising = i_fast_rise;
        if (o_emit) begin
            n_holdoff = (w_len == '0) ? '0 : w_len - 1'b1;
        end else if (r_holdoff != '0) begin
            n_holdoff = r_holdoff - 1'b1;
        end else begin
            n_holdoff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rising  <= 1'b0;
            r_holdoff <= '0;
        end else if (i_advance) begin
            r_rising  <= n_rising;
            r_holdoff <= n_holdoff;
        end
    end

    a_no_emit_in_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_holdoff != '0) |-> !o_emit)
        else $error("pulse emitted while the holdoff counter runs");

    a_emit_loads_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_emit && (w_len > 1)) |=> (r_holdoff != '0))
        else $error("holdoff counter not loaded after a pulse");

    a_emit_needs_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_emit) |=> !r_rising)
        else $error("rise flag survives a pulse");

endmodule

// ===== sv/peak_onset_detector.sv =====
// A sample beat is registered in the input stage, and its result beat in the result stage once it moves forward.
// Throughput: one sample per cycle while results are taken; both envelope updates and the onset decision sit between
// the input register and the result register, and the envelope feedback closes through the envelope registers alone.
// Reset (i_rst_n low, synchronous): envelopes, rise flag and holdoff counter clear to zero,
// the configuration registers return to their defaults, and both pipeline stages empty.
module peak_onset_detector #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 24,
    parameter int HOLDOFF_BITS   = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample channel.
    input  logic                               i_sample_valid,
    output logic                               o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    // Result channel.
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic                               o_pulse,
    output logic signed [SAMPLE_BITS-1:0]      o_level,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pod_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [pod_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    // Envelopes carry the sample as their integer part and COEF_FRAC_BITS of fraction.
    localparam int EB = SAMPLE_BITS + COEF_FRAC_BITS;

    // Configuration registers.
    pod_pkg::t_cfg r_cfg;

    // Input stage: the accepted sample waits here until it moves forward.
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample;

    // Envelope state.
    logic [EB-1:0] r_fast_env;
    logic [EB-1:0] r_slow_env;

    // Result stage.
    logic                   r_out_valid;
    logic                   r_pulse;
    logic [SAMPLE_BITS-1:0] r_level;

    logic                                      w_advance;
    logic [EB-1:0]                             w_xs;
    logic [EB-1:0]                             n_fast_env;
    logic [EB-1:0]                             n_slow_env;
    logic                                      w_fast_rise;
    logic                                      w_slow_rise;
    logic                                      w_emit;
    logic [COEF_FRAC_BITS+pod_pkg::DECAY_BITS-1:0] w_fast_ext;
    logic [COEF_FRAC_BITS+pod_pkg::DECAY_BITS-1:0] w_slow_ext;
    logic [COEF_FRAC_BITS-1:0]                 w_fast_a;
    logic [COEF_FRAC_BITS-1:0]                 w_slow_a;

    // The input stage moves forward whenever the result stage is empty or is being drained.
    // A new beat is taken whenever the input stage is empty or moves forward in this cycle,
    // so while a finished result waits downstream, one more sample can still enter an empty
    // input stage; after that the sample channel stalls until the result is taken.
    assign w_advance      = r_in_valid && (!r_out_valid || i_result_ready);
    assign o_sample_ready = !r_in_valid || w_advance;
    assign o_cfg_ready    = 1'b1;

    assign o_result_valid = r_out_valid;
    assign o_pulse        = r_pulse;
    assign o_level        = r_level;

    // The decay factors are cut or padded to the fraction width before use.
    assign w_fast_ext = {{COEF_FRAC_BITS{1'b0}}, r_cfg.fast_decay};
    assign w_slow_ext = {{COEF_FRAC_BITS{1'b0}}, r_cfg.slow_decay};
    assign w_fast_a   = w_fast_ext[COEF_FRAC_BITS-1:0];
    assign w_slow_a   = w_slow_ext[COEF_FRAC_BITS-1:0];

    // The sample scaled to envelope format.
    assign w_xs = {r_sample, {COEF_FRAC_BITS{1'b0}}};

    pod_env_update #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_fast_env (
        .i_env   (r_fast_env),
        .i_xs    (w_xs),
        .i_decay (w_fast_a),
        .o_env   (n_fast_env),
        .o_rise  (w_fast_rise)
    );

    pod_env_update #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_slow_env (
        .i_env   (r_slow_env),
        .i_xs    (w_xs),
        .i_decay (w_slow_a),
        .o_env   (n_slow_env),
        .o_rise  (w_slow_rise)
    );

    // The onset decision looks at both envelopes after this sample's update.
    pod_onset #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HOLDOFF_BITS   (HOLDOFF_BITS)
    ) u_onset (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_fast_rise (w_fast_rise),
        .i_fast_env  (n_fast_env),
        .i_slow_env  (n_slow_env),
        .i_cfg       (r_cfg),
        .o_emit      (w_emit)
    );

    // Configuration writes. Every two-bit index names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_decay     <= pod_pkg::RST_FAST_DECAY;
            r_cfg.slow_decay     <= pod_pkg::RST_SLOW_DECAY;
            r_cfg.holdoff_length <= pod_pkg::RST_HOLDOFF_LENGTH;
            r_cfg.min_level      <= pod_pkg::RST_MIN_LEVEL;
        end else if (i_cfg_valid) begin
            unique case (pod_pkg::t_cfg_index'(i_cfg_index))
                pod_pkg::CFG_FAST_DECAY: begin
                    r_cfg.fast_decay <= i_cfg_data[pod_pkg::DECAY_BITS-1:0];
                end
                pod_pkg::CFG_SLOW_DECAY: begin
                    r_cfg.slow_decay <= i_cfg_data[pod_pkg::DECAY_BITS-1:0];
                end
                pod_pkg::CFG_HOLDOFF_LENGTH: begin
                    r_cfg.holdoff_length <= i_cfg_data[pod_pkg::HOLD_REG_BITS-1:0];
                end
                pod_pkg::CFG_MIN_LEVEL: begin
                    r_cfg.min_level <= i_cfg_data[pod_pkg::MIN_BITS-1:0];
                end
            endcase
        end
    end

    // Pipeline control and envelope state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fast_env  <= '0;
            r_slow_env  <= '0;
        end else begin
            if (o_sample_ready) begin
                r_in_valid <= i_sample_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_fast_env  <= n_fast_env;
                r_slow_env  <= n_slow_env;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_sample_ready && i_sample_valid) begin
            r_sample <= i_sample;
        end
        if (w_advance) begin
            r_pulse <= w_emit;
            r_level <= n_fast_env[EB-1:COEF_FRAC_BITS];
        end
    end

    a_state_holds_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_fast_env) && $stable(r_slow_env)))
        else $error("envelope state changed without a sample moving forward");

    a_pulse_above_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_pulse) |->
            ($signed(o_level) >= $signed({1'b0, r_cfg.min_level})))
        else $error("pulse reported with the level below the minimum");

    a_slow_rise_follows_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_fast_rise) |=>
            ($signed(r_fast_env) >= $signed(r_slow_env) || !$past(w_slow_rise)))
        else $error("fast envelope below the slow one after both jumped");

endmodule
